// File: rtl/scaled_horner_poly_eval_defines.svh
// ---------------------------------------------------------------------------
// Scaled Horner polynomial evaluator: assertion macros
// Shared helpers for the concurrent checks in the RTL modules.
// ---------------------------------------------------------------------------
`ifndef SCALED_HORNER_POLY_EVAL_DEFINES_SVH
`define SCALED_HORNER_POLY_EVAL_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define SHPE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define SHPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/shpe_pkg.sv
// ---------------------------------------------------------------------------
// Scaled Horner polynomial evaluator: package
// Widths, register indexes, the stage bundle and the 32-bit clip function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package shpe_pkg;

	localparam int DATA_W        = 32;
	localparam int WIDE_W        = 65;
	localparam int NUM_COEFFS    = 6;
	localparam int REG_IDX_W     = 3;
	localparam int DEF_NUM_TERMS = 6;
	localparam int DEF_FRAC_BITS = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OFFSET,
		REG_INV_SCALE,
		REG_COEFF_ZERO,
		REG_COEFF_ONE,
		REG_COEFF_TWO,
		REG_COEFF_THREE,
		REG_COEFF_FOUR,
		REG_COEFF_FIVE
	} reg_idx_t;

	// One item between Horner steps.
	typedef struct packed {
		logic                     valid;
		logic                     sat;
		logic signed [DATA_W-1:0] xc;
		logic signed [DATA_W-1:0] acc;
	} shpe_stage_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     clipped;
	} sat_res_t;

	// Clip a wide signed value to 32 bits and report whether it was clipped.
	function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] v);
		sat_res_t r;
		if ((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1])) begin
			r.value   = v[DATA_W-1:0];
			r.clipped = 1'b0;
		end else begin
			r.value   = v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
			r.clipped = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: rtl/shpe_horner_step.sv
// ---------------------------------------------------------------------------
// Scaled Horner polynomial evaluator: one Horner step
// Two stages: acc * xc, then round, add the coefficient and clip.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scaled_horner_poly_eval_defines.svh"

module shpe_horner_step #(
	parameter int FRAC_BITS = shpe_pkg::DEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic signed [shpe_pkg::DATA_W-1:0] coeff,
	input  shpe_pkg::shpe_stage_t              in_stage,
	output shpe_pkg::shpe_stage_t              out_stage
);
	import shpe_pkg::*;

	localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

	logic                       valid_s1;
	logic                       sat_s1;
	logic signed [DATA_W-1:0]   xc_s1;
	logic signed [2*DATA_W-1:0] prod_s1;

	logic                       valid_s2;
	logic                       sat_s2;
	logic signed [DATA_W-1:0]   xc_s2;
	logic signed [DATA_W-1:0]   acc_s2;

	logic signed [WIDE_W-1:0]   rnd;
	logic signed [WIDE_W-1:0]   sum;
	sat_res_t                   sum_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_stage.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s1  <= in_stage.sat;
			xc_s1   <= in_stage.xc;
			prod_s1 <= (2*DATA_W)'($signed(in_stage.xc)) * (2*DATA_W)'($signed(in_stage.acc));
			sat_s2  <= sat_s1 | sum_sat.clipped;
			xc_s2   <= xc_s1;
			acc_s2  <= sum_sat.value;
		end
	end

	// Rounding adds half an LSB and then floors, so ties go toward +infinity.
	always_comb begin
		rnd     = ($signed({prod_s1[2*DATA_W-1], prod_s1}) + HALF) >>> FRAC_BITS;
		sum     = rnd + $signed({{(WIDE_W-DATA_W){coeff[DATA_W-1]}}, coeff});
		sum_sat = sat32(sum);
	end

	assign out_stage.valid = valid_s2;
	assign out_stage.sat   = sat_s2;
	assign out_stage.xc    = xc_s2;
	assign out_stage.acc   = acc_s2;

	`SHPE_ASSERT_NEXT(a_sat_sticky, en && in_stage.valid && in_stage.sat, sat_s1, "sat flag lost in step")
	`SHPE_ASSERT_NEXT(a_zero_prod, en && valid_s1 && prod_s1 == '0 && !sat_s1, acc_s2 == $past(coeff) && !sat_s2, "zero product must yield the coefficient")
	`SHPE_ASSERT_NEXT(a_valid_adv, en && valid_s1, valid_s2, "item dropped between step stages")

endmodule

// File: rtl/scaled_horner_poly_eval.sv
// Scaled Horner polynomial evaluator. Each item carries one Q-format sample x; the block
// returns y = c0 + c1*xc + ... + c(NUM_TERMS-1)*xc^(NUM_TERMS-1) with xc = (x - offset) *
// inv_scale, every intermediate rounded and clipped to 32 bits, and tuser set if any value
// was clipped. One item enters per clock while the output is not stalled. The front end
// registers the centred sample, the scaled product and the rounded xc; each Horner step has
// a two-stage multiply/add. The whole pipeline holds while a finished result is not taken.
// The user must write registers only while no item is in flight; the block does not check.
// ---------------------------------------------------------------------------
// Scaled Horner polynomial evaluator: top level
// Config registers, centering and scaling front end, chain of Horner steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scaled_horner_poly_eval_defines.svh"

module scaled_horner_poly_eval #(
	parameter int NUM_TERMS = shpe_pkg::DEF_NUM_TERMS,
	parameter int FRAC_BITS = shpe_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [shpe_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [shpe_pkg::DATA_W-1:0]          cfg_wdata,
	// Input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [shpe_pkg::DATA_W-1:0]          s_axis_tdata,  // [31:0] x_value
	// Output stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [shpe_pkg::DATA_W-1:0]          m_axis_tdata,  // [31:0] y_value
	output logic                                 m_axis_tuser   // [0] saturated
);
	import shpe_pkg::*;

	localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);
	localparam logic [DATA_W-1:0]        ONE  = DATA_W'(1) << FRAC_BITS;

	logic signed [DATA_W-1:0] offset_q;
	logic        [DATA_W-1:0] inv_scale_q;
	logic signed [DATA_W-1:0] coeff_q [NUM_COEFFS];

	logic                     en;

	logic                     valid_s1;
	logic                     sat_s1;
	logic signed [DATA_W-1:0] d_s1;

	logic                     valid_s2;
	logic                     sat_s2;
	logic signed [WIDE_W-1:0] prod_s2;

	logic                     valid_s3;
	logic                     sat_s3;
	logic signed [DATA_W-1:0] xc_s3;

	logic signed [DATA_W:0]   diff;
	sat_res_t                 d_sat;
	logic signed [WIDE_W-1:0] xc_rnd;
	sat_res_t                 xc_sat;

	shpe_stage_t              chain [NUM_TERMS];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			inv_scale_q <= ONE;
			for (int i = 0; i < NUM_COEFFS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_addr))
				REG_OFFSET:      offset_q    <= cfg_wdata;
				REG_INV_SCALE:   inv_scale_q <= cfg_wdata;
				REG_COEFF_ZERO:  coeff_q[0]  <= cfg_wdata;
				REG_COEFF_ONE:   coeff_q[1]  <= cfg_wdata;
				REG_COEFF_TWO:   coeff_q[2]  <= cfg_wdata;
				REG_COEFF_THREE: coeff_q[3]  <= cfg_wdata;
				REG_COEFF_FOUR:  coeff_q[4]  <= cfg_wdata;
				REG_COEFF_FIVE:  coeff_q[5]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the output holds an item not yet taken.
	assign en            = !chain[NUM_TERMS-1].valid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		diff   = $signed({s_axis_tdata[DATA_W-1], s_axis_tdata})
		       - $signed({offset_q[DATA_W-1], offset_q});
		d_sat  = sat32($signed({{(WIDE_W-DATA_W-1){diff[DATA_W]}}, diff}));
		xc_rnd = (prod_s2 + HALF) >>> FRAC_BITS;
		xc_sat = sat32(xc_rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d_sat.value;
			sat_s1  <= d_sat.clipped;
			prod_s2 <= WIDE_W'(d_s1) * WIDE_W'($signed({1'b0, inv_scale_q}));
			sat_s2  <= sat_s1;
			xc_s3   <= xc_sat.value;
			sat_s3  <= sat_s2 | xc_sat.clipped;
		end
	end

	// Horner starts from the highest coefficient.
	assign chain[0].valid = valid_s3;
	assign chain[0].sat   = sat_s3;
	assign chain[0].xc    = xc_s3;
	assign chain[0].acc   = coeff_q[NUM_TERMS-1];

	for (genvar k = 0; k < NUM_TERMS - 1; k++) begin : g_step
		shpe_horner_step #(
			.FRAC_BITS (FRAC_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.coeff     (coeff_q[NUM_TERMS-2-k]),
			.in_stage  (chain[k]),
			.out_stage (chain[k+1])
		);
	end

	assign m_axis_tvalid = chain[NUM_TERMS-1].valid;
	assign m_axis_tdata  = chain[NUM_TERMS-1].acc;
	assign m_axis_tuser  = chain[NUM_TERMS-1].sat;

	`SHPE_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_s1, "accepted item missing from first stage")
	`SHPE_ASSERT_NEXT(a_front_adv, en && valid_s2, valid_s3, "item dropped in front end")
	`SHPE_ASSERT_SAME(a_zero_scale, valid_s3 && inv_scale_q == '0, xc_s3 == '0, "zero inv_scale must give zero xc")

endmodule
